### rtl/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg
// Shared types, phase codes, register map and thresholds for the obstacle
// bypass sequencer.
// ----------------------------------------------------------------------------
package obs_pkg;

  // Phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SWERVE = 2'd1;
  localparam logic [1:0] PH_BYPASS = 2'd2;
  localparam logic [1:0] PH_RETURN = 2'd3;

  // Register map (word index)
  localparam logic [2:0] REG_BYPASS_LEFT  = 3'd0;
  localparam logic [2:0] REG_SWERVE_ANGLE = 3'd1;
  localparam logic [2:0] REG_RETURN_ANGLE = 3'd2;
  localparam logic [2:0] REG_GAINS_SWERVE = 3'd3;
  localparam logic [2:0] REG_GAINS_BYPASS = 3'd4;
  localparam logic [2:0] REG_GAINS_STRGHT = 3'd5;

  // Field widths
  localparam int DIST_W   = 31;
  localparam int HEAD_W   = 17;
  localparam int COIL_W   = 16;
  localparam int TIME_W   = 32;
  localparam int ANGLE_W  = 7;
  localparam int OFFS_W   = 18;
  localparam int DELTA_W  = 19;
  localparam int GAIN_W   = 16;
  localparam int PPROD_W  = OFFS_W + GAIN_W + 1;
  localparam int DPROD_W  = DELTA_W + GAIN_W + 1;
  localparam int STEER_W  = 9;

  // Distance thresholds since the last phase mark
  localparam logic signed [31:0] DIST_SWERVE       = 32'sd60;
  localparam logic signed [31:0] DIST_BYPASS_LEFT  = 32'sd40;
  localparam logic signed [31:0] DIST_BYPASS_RIGHT = 32'sd30;
  localparam logic signed [31:0] DIST_EXIT         = 32'sd30;

  // Heading margin in Q.8 degrees
  localparam logic signed [OFFS_W-1:0] ANGLE_MARGIN_Q8 = 18'sd1280;

  // Exit conditions, bypass and return phases
  localparam logic signed [COIL_W-1:0] B_COIL_LOW   = 16'sd50;
  localparam logic signed [COIL_W-1:0] B_COIL_HIGH  = 16'sd200;
  localparam logic signed [OFFS_W-1:0] B_HEAD_LIMIT = 18'sd10240;
  localparam logic signed [COIL_W-1:0] R_COIL_LOW   = 16'sd35;
  localparam logic signed [COIL_W-1:0] R_COIL_HIGH  = 16'sd180;
  localparam logic signed [OFFS_W-1:0] R_HEAD_LIMIT = 18'sd7680;

  localparam logic [TIME_W-1:0] TIMEOUT_TICKS = 32'd40000;

  // Output scaling: steer = trunc(sum / 2^16 / GAIN_DIV), clamped
  localparam int STEER_LIMIT = 250;
  localparam int GAIN_DIV    = 10;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (2**RECIP_SHIFT + GAIN_DIV - 1) / GAIN_DIV;
  localparam int CLAMP_RAW   = (STEER_LIMIT + 1) * GAIN_DIV;

  typedef struct packed {
    logic               bypass_left;
    logic [ANGLE_W-1:0] swerve_angle;
    logic [ANGLE_W-1:0] return_angle;
    logic [31:0]        gains_swerve;
    logic [31:0]        gains_bypass;
    logic [31:0]        gains_straighten;
  } obs_cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       active;
    logic       done;
    logic       stop;
  } obs_stat_t;

  typedef struct packed {
    logic signed [OFFS_W-1:0]  offset;
    logic signed [DELTA_W-1:0] delta;
    logic [GAIN_W-1:0]         p_gain;
    logic [GAIN_W-1:0]         d_gain;
  } obs_corr_t;

endpackage

### rtl/obs_phase_ctrl.sv
// ----------------------------------------------------------------------------
// obs_phase_ctrl
// Phase machine and sequencer state: start, phase advance, exit, timeout
// and the heading error terms for the correction of one tick.
// ----------------------------------------------------------------------------
module obs_phase_ctrl
  import obs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  obs_cfg_t                 cfg_i,
  input  logic                     start_request_i,
  input  logic [DIST_W-1:0]        travel_distance_i,
  input  logic signed [HEAD_W-1:0] heading_angle_i,
  input  logic signed [COIL_W-1:0] center_coil_i,
  input  logic [TIME_W-1:0]        time_ticks_i,
  output obs_stat_t                stat_o,
  output obs_corr_t                corr_o
);

  logic [1:0]               phase_q, phase_d;
  logic [DIST_W-1:0]        mark_q, mark_d;
  logic [TIME_W-1:0]        start_q, start_d;
  logic signed [OFFS_W-1:0] prev_q, prev_d;
  logic                     done_q, done_d;
  logic                     stop_q, stop_d;

  logic signed [OFFS_W-1:0]  head;
  logic signed [OFFS_W-1:0]  sw_lim;
  logic signed [OFFS_W-1:0]  rt_lim;
  logic signed [31:0]        since;
  logic                      exit_b;
  logic                      exit_r;
  logic                      turn_b;
  logic signed [7:0]         target;
  logic signed [OFFS_W-1:0]  offset;
  logic signed [DELTA_W-1:0] delta;
  logic [31:0]               gains;
  logic [TIME_W-1:0]         elapsed;

  assign head   = OFFS_W'(heading_angle_i);
  assign sw_lim = $signed({3'b0, cfg_i.swerve_angle, 8'b0}) - ANGLE_MARGIN_Q8;
  assign rt_lim = $signed({3'b0, cfg_i.return_angle, 8'b0}) - ANGLE_MARGIN_Q8;

  assign exit_b = (center_coil_i > B_COIL_LOW && head > -B_HEAD_LIMIT &&
                   head < B_HEAD_LIMIT) || center_coil_i > B_COIL_HIGH;
  assign exit_r = (center_coil_i > R_COIL_LOW && head > -R_HEAD_LIMIT &&
                   head < R_HEAD_LIMIT) || center_coil_i > R_COIL_HIGH;

  always_comb begin
    phase_d = phase_q;
    mark_d  = mark_q;
    start_d = start_q;
    prev_d  = prev_q;
    done_d  = done_q;
    stop_d  = stop_q;

    if (phase_d == PH_IDLE && start_request_i) begin
      phase_d = PH_SWERVE;
      mark_d  = travel_distance_i;
      start_d = time_ticks_i;
    end

    since  = $signed({1'b0, travel_distance_i}) - $signed({1'b0, mark_d});
    turn_b = cfg_i.bypass_left ? (since > DIST_BYPASS_LEFT && head < -rt_lim)
                               : (since > DIST_BYPASS_RIGHT && head > rt_lim);

    case (phase_d)
      PH_SWERVE: begin
        if (since > DIST_SWERVE &&
            (cfg_i.bypass_left ? head > sw_lim : head < -sw_lim)) begin
          phase_d = PH_BYPASS;
          mark_d  = travel_distance_i;
        end
      end
      PH_BYPASS: begin
        // a fresh mark leaves no distance for the exit check
        if (turn_b) begin
          phase_d = PH_RETURN;
          mark_d  = travel_distance_i;
        end else if (exit_b && since > DIST_EXIT) begin
          phase_d = PH_IDLE;
          mark_d  = travel_distance_i;
          start_d = '0;
          done_d  = 1'b1;
        end
      end
      PH_RETURN: begin
        if (exit_r && since > DIST_EXIT) begin
          phase_d = PH_IDLE;
          mark_d  = travel_distance_i;
          start_d = '0;
          done_d  = 1'b1;
        end
      end
      default: ;
    endcase

    case (phase_d)
      PH_SWERVE: begin
        target = cfg_i.bypass_left ? $signed({1'b0, cfg_i.swerve_angle})
                                   : -$signed({1'b0, cfg_i.swerve_angle});
        gains  = cfg_i.gains_swerve;
      end
      PH_BYPASS: begin
        target = cfg_i.bypass_left ? -$signed({1'b0, cfg_i.return_angle})
                                   : $signed({1'b0, cfg_i.return_angle});
        gains  = cfg_i.gains_bypass;
      end
      default: begin
        target = '0;
        gains  = cfg_i.gains_straighten;
      end
    endcase

    offset  = head - $signed({{2{target[7]}}, target, 8'b0});
    delta   = DELTA_W'(offset) - DELTA_W'(prev_q);
    elapsed = time_ticks_i - start_d;

    if (phase_d != PH_IDLE) begin
      prev_d = offset;
      if (elapsed >= TIMEOUT_TICKS) begin
        stop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mark_q  <= '0;
      start_q <= '0;
      prev_q  <= '0;
      done_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
      start_q <= start_d;
      prev_q  <= prev_d;
      done_q  <= done_d;
      stop_q  <= stop_d;
    end
  end

  assign stat_o.phase  = phase_d;
  assign stat_o.active = (phase_d != PH_IDLE);
  assign stat_o.done   = done_d;
  assign stat_o.stop   = stop_d;

  assign corr_o.offset = offset;
  assign corr_o.delta  = delta;
  assign corr_o.p_gain = gains[31:16];
  assign corr_o.d_gain = gains[15:0];

  a_done_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q) else $error("bypass_done dropped");

  a_stop_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q) else $error("stop flag dropped");

  a_idle_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |=> (phase_q == PH_IDLE || phase_q == PH_SWERVE))
    else $error("idle left for a phase other than swerve");

  a_swerve_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SWERVE) |=> (phase_q == PH_SWERVE || phase_q == PH_BYPASS))
    else $error("swerve left for a phase other than bypass");

endmodule

### rtl/obs_steer_scale.sv
// ----------------------------------------------------------------------------
// obs_steer_scale
// Sums the P and D products, scales by 1/(2^16 * 10) with truncation toward
// zero and clamps to the steering limit; the output is zero while not active.
// ----------------------------------------------------------------------------
module obs_steer_scale
  import obs_pkg::*;
(
  input  logic                      active_i,
  input  logic signed [PPROD_W-1:0] p_prod_i,
  input  logic signed [DPROD_W-1:0] d_prod_i,
  output logic signed [STEER_W-1:0] steer_o
);

  localparam int SUM_W = DPROD_W + 1;
  localparam int RAW_W = SUM_W - RECIP_SHIFT;
  localparam int QIN_W = $clog2(CLAMP_RAW);
  localparam int RCP_W = $clog2(RECIP + 1);
  localparam int QP_W  = QIN_W + RCP_W;

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag;
  logic [RAW_W-1:0]        raw;
  logic [QP_W-1:0]         qprod;
  logic [STEER_W-2:0]      quot;
  logic [STEER_W-1:0]      quot_ext;

  assign sum = SUM_W'(p_prod_i) + SUM_W'(d_prod_i);
  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign raw = mag[SUM_W-1:RECIP_SHIFT];

  // divide by ten through a reciprocal, exact below the clamp point
  assign qprod = QP_W'(raw[QIN_W-1:0]) * QP_W'(RECIP);

  always_comb begin
    if (raw >= RAW_W'(CLAMP_RAW)) begin
      quot = (STEER_W-1)'(STEER_LIMIT);
    end else begin
      quot = qprod[RECIP_SHIFT +: (STEER_W-1)];
    end
    quot_ext = {1'b0, quot};
    if (!active_i) begin
      steer_o = '0;
    end else if (sum[SUM_W-1]) begin
      steer_o = -$signed(quot_ext);
    end else begin
      steer_o = $signed(quot_ext);
    end
  end

endmodule

### rtl/obstacle_bypass_sequencer.sv
// ----------------------------------------------------------------------------
// obstacle_bypass_sequencer
// Obstacle bypass phase sequencer with PD steering correction.
// ----------------------------------------------------------------------------
// One control tick goes in per transfer and one result comes out per tick, in
// order. The block takes a new tick every clock cycle while the result side
// keeps up; a tick passes through the input register, the product register and
// the result register in that order. The phase state is updated as a tick
// leaves the input register, so the next tick sees it at once. Registers must
// be written over the APB port only while no tick is in flight; the block
// itself does not enforce this. pready is always high.
module obstacle_bypass_sequencer
  import obs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      start_request_i,
  input  logic [DIST_W-1:0]         travel_distance_i,
  input  logic signed [HEAD_W-1:0]  heading_angle_i,
  input  logic signed [COIL_W-1:0]  center_coil_i,
  input  logic [TIME_W-1:0]         time_ticks_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                phase_o,
  output logic signed [STEER_W-1:0] steer_error_o,
  output logic                      bypass_done_o,
  output logic                      stop_car_o
);

  obs_cfg_t   cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass_left      <= 1'b1;
      cfg_q.swerve_angle     <= 7'd30;
      cfg_q.return_angle     <= 7'd30;
      cfg_q.gains_swerve     <= '0;
      cfg_q.gains_bypass     <= '0;
      cfg_q.gains_straighten <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BYPASS_LEFT:  cfg_q.bypass_left      <= pwdata[0];
        REG_SWERVE_ANGLE: cfg_q.swerve_angle     <= pwdata[ANGLE_W-1:0];
        REG_RETURN_ANGLE: cfg_q.return_angle     <= pwdata[ANGLE_W-1:0];
        REG_GAINS_SWERVE: cfg_q.gains_swerve     <= pwdata;
        REG_GAINS_BYPASS: cfg_q.gains_bypass     <= pwdata;
        REG_GAINS_STRGHT: cfg_q.gains_straighten <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BYPASS_LEFT:  prdata = {31'b0, cfg_q.bypass_left};
      REG_SWERVE_ANGLE: prdata = {25'b0, cfg_q.swerve_angle};
      REG_RETURN_ANGLE: prdata = {25'b0, cfg_q.return_angle};
      REG_GAINS_SWERVE: prdata = cfg_q.gains_swerve;
      REG_GAINS_BYPASS: prdata = cfg_q.gains_bypass;
      REG_GAINS_STRGHT: prdata = cfg_q.gains_straighten;
      default:          prdata = '0;
    endcase
  end

  // Pipeline handshake: each stage advances when the one after it has room
  logic in_v_q, prod_v_q, out_v_q;
  logic in_rdy, prod_rdy, out_rdy;
  logic adv;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign prod_rdy   = !prod_v_q || out_rdy;
  assign in_rdy     = !in_v_q || prod_rdy;
  assign in_ready_o = in_rdy;
  assign adv        = in_v_q && prod_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_v_q <= in_valid_i;
      end
      if (prod_rdy) begin
        prod_v_q <= in_v_q;
      end
      if (out_rdy) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  // Input register
  logic                     start_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [HEAD_W-1:0] head_q;
  logic signed [COIL_W-1:0] coil_q;
  logic [TIME_W-1:0]        time_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_rdy) begin
      start_q <= start_request_i;
      dist_q  <= travel_distance_i;
      head_q  <= heading_angle_i;
      coil_q  <= center_coil_i;
      time_q  <= time_ticks_i;
    end
  end

  obs_stat_t stat;
  obs_corr_t corr;

  obs_phase_ctrl u_phase_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .cfg_i             (cfg_q),
    .start_request_i   (start_q),
    .travel_distance_i (dist_q),
    .heading_angle_i   (head_q),
    .center_coil_i     (coil_q),
    .time_ticks_i      (time_q),
    .stat_o            (stat),
    .corr_o            (corr)
  );

  // Product register
  obs_stat_t                 stat_q;
  logic signed [PPROD_W-1:0] p_prod_q;
  logic signed [DPROD_W-1:0] d_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stat_q   <= stat;
      p_prod_q <= PPROD_W'(corr.offset) * $signed({1'b0, corr.p_gain});
      d_prod_q <= DPROD_W'(corr.delta) * $signed({1'b0, corr.d_gain});
    end
  end

  logic signed [STEER_W-1:0] steer;

  obs_steer_scale u_steer_scale (
    .active_i (stat_q.active),
    .p_prod_i (p_prod_q),
    .d_prod_i (d_prod_q),
    .steer_o  (steer)
  );

  // Result register
  logic [1:0]                phase_q;
  logic signed [STEER_W-1:0] steer_q;
  logic                      done_q;
  logic                      stop_q;

  always_ff @(posedge clk_i) begin
    if (prod_v_q && out_rdy) begin
      phase_q <= stat_q.phase;
      steer_q <= steer;
      done_q  <= stat_q.done;
      stop_q  <= stat_q.stop;
    end
  end

  assign out_valid_o   = out_v_q;
  assign phase_o       = phase_q;
  assign steer_error_o = steer_q;
  assign bypass_done_o = done_q;
  assign stop_car_o    = stop_q;

  a_steer_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steer_error_o <= 9'sd250 && steer_error_o >= -9'sd250))
    else $error("steering correction outside the limit");

  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_o == PH_IDLE) |-> (steer_error_o == '0))
    else $error("nonzero correction in idle");

endmodule

### bench/tb_obstacle_bypass_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obstacle_bypass_sequencer
// Self-checking bench for the obstacle bypass sequencer. Control ticks go in
// over valid/ready and are predicted by a bit-accurate copy of the phase
// machine and PD steering math. Each result transfer is compared against
// the oldest prediction. The stimulus is a short directed walk through every
// phase on both bypass sides. After that come random odometer-coherent runs
// that steer the heading toward the next phase, plus some noise ticks, under
// several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_obstacle_bypass_sequencer;
  import obs_pkg::*;

  localparam int     ITEMS_PER_PHASE = 210;
  localparam int     NUM_PHASES      = 8;
  localparam int     TIMEOUT_PHASE   = 6;
  localparam int     DRAIN_CYCLES    = 10;
  localparam int     CYCLE_LIMIT     = 200000;
  localparam int     HEAD_MAX        = 46080;
  localparam longint STEER_DIVISOR   = (longint'(1) << RECIP_SHIFT) * GAIN_DIV;

  typedef struct {
    logic                     start;
    logic [DIST_W-1:0]        odo;
    logic signed [HEAD_W-1:0] heading;
    logic signed [COIL_W-1:0] coil;
    logic [TIME_W-1:0]        ticks;
  } tick_t;

  typedef struct {
    logic [1:0]                phase;
    logic signed [STEER_W-1:0] steer;
    logic                      done;
    logic                      stop;
  } steer_out_t;

  class bypass_scoreboard;
    logic               left;
    logic [ANGLE_W-1:0] swerve_deg;
    logic [ANGLE_W-1:0] return_deg;
    logic [31:0]        g_swerve;
    logic [31:0]        g_bypass;
    logic [31:0]        g_straight;
    logic [1:0]         ph;
    logic [31:0]        mark;
    logic [31:0]        t_start;
    longint             prev_offs;
    logic               done;
    logic               stop;
    steer_out_t         expected_steer_q[$];
    int                 errors;

    function new();
      left       = 1'b1;
      swerve_deg = 7'd30;
      return_deg = 7'd30;
      g_swerve   = '0;
      g_bypass   = '0;
      g_straight = '0;
      ph         = PH_IDLE;
      mark       = '0;
      t_start    = '0;
      prev_offs  = 0;
      done       = 1'b0;
      stop       = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_BYPASS_LEFT:  left       = value[0];
        REG_SWERVE_ANGLE: swerve_deg = value[ANGLE_W-1:0];
        REG_RETURN_ANGLE: return_deg = value[ANGLE_W-1:0];
        REG_GAINS_SWERVE: g_swerve   = value;
        REG_GAINS_BYPASS: g_bypass   = value;
        REG_GAINS_STRGHT: g_straight = value;
        default: ;
      endcase
    endfunction

    function void complete_bypass(logic [DIST_W-1:0] odo);
      mark    = {1'b0, odo};
      ph      = PH_IDLE;
      done    = 1'b1;
      t_start = '0;
    endfunction

    function void note_tick(tick_t t);
      longint      head, coil, since, sw_lim, rt_lim;
      longint      tgt, offs, dlt, sum, steer;
      logic [31:0] gains;
      logic [31:0] elapsed;
      steer_out_t  want;
      head   = longint'(t.heading);
      coil   = longint'(t.coil);
      sw_lim = longint'(swerve_deg) * 256 - longint'(ANGLE_MARGIN_Q8);
      rt_lim = longint'(return_deg) * 256 - longint'(ANGLE_MARGIN_Q8);
      steer  = 0;

      if (ph == PH_IDLE && t.start) begin
        ph      = PH_SWERVE;
        mark    = {1'b0, t.odo};
        t_start = t.ticks;
      end

      since = longint'(t.odo) - longint'(mark);

      case (ph)
        PH_SWERVE: begin
          if (since > DIST_SWERVE && (left ? (head > sw_lim) : (head < -sw_lim))) begin
            ph   = PH_BYPASS;
            mark = {1'b0, t.odo};
          end
        end
        PH_BYPASS: begin
          if (left ? (since > DIST_BYPASS_LEFT && head < -rt_lim)
                   : (since > DIST_BYPASS_RIGHT && head > rt_lim)) begin
            ph   = PH_RETURN;
            mark = {1'b0, t.odo};
          end
          // the exit test sees the distance from the mark just taken
          since = longint'(t.odo) - longint'(mark);
          if (((coil > B_COIL_LOW && (head < 0 ? -head : head) < B_HEAD_LIMIT) ||
               coil > B_COIL_HIGH) && since > DIST_EXIT)
            complete_bypass(t.odo);
        end
        PH_RETURN: begin
          if (((coil > R_COIL_LOW && (head < 0 ? -head : head) < R_HEAD_LIMIT) ||
               coil > R_COIL_HIGH) && since > DIST_EXIT)
            complete_bypass(t.odo);
        end
        default: ;
      endcase

      if (ph != PH_IDLE) begin
        case (ph)
          PH_SWERVE: begin
            tgt   = left ? longint'(swerve_deg) : -longint'(swerve_deg);
            gains = g_swerve;
          end
          PH_BYPASS: begin
            tgt   = left ? -longint'(return_deg) : longint'(return_deg);
            gains = g_bypass;
          end
          default: begin
            tgt   = 0;
            gains = g_straight;
          end
        endcase
        offs  = head - tgt * 256;
        dlt   = offs - prev_offs;
        sum   = offs * longint'(gains[31:16]) + dlt * longint'(gains[15:0]);
        steer = sum / STEER_DIVISOR;
        if (steer > STEER_LIMIT) steer = STEER_LIMIT;
        if (steer < -STEER_LIMIT) steer = -STEER_LIMIT;
        elapsed = t.ticks - t_start;
        if (elapsed >= TIMEOUT_TICKS) stop = 1'b1;
        prev_offs = offs;
      end

      want.phase = ph;
      want.steer = STEER_W'(steer);
      want.done  = done;
      want.stop  = stop;
      expected_steer_q.push_back(want);
    endfunction

    function void check_result(steer_out_t got);
      steer_out_t want;
      if (expected_steer_q.size() == 0) begin
        $display("%0t: result with nothing expected: phase %0d steer %0d done %0b stop %0b",
                 $time, got.phase, got.steer, got.done, got.stop);
        errors++;
        return;
      end
      want = expected_steer_q.pop_front();
      if (got.phase !== want.phase) begin
        $display("%0t: phase mismatch, expected %0d, got %0d", $time, want.phase, got.phase);
        errors++;
      end
      if (got.steer !== want.steer) begin
        $display("%0t: steer_error mismatch, expected %0d, got %0d",
                 $time, want.steer, got.steer);
        errors++;
      end
      if (got.done !== want.done) begin
        $display("%0t: bypass_done mismatch, expected %0b, got %0b",
                 $time, want.done, got.done);
        errors++;
      end
      if (got.stop !== want.stop) begin
        $display("%0t: stop_car mismatch, expected %0b, got %0b", $time, want.stop, got.stop);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [4:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      start_request_i;
  logic [DIST_W-1:0]         travel_distance_i;
  logic signed [HEAD_W-1:0]  heading_angle_i;
  logic signed [COIL_W-1:0]  center_coil_i;
  logic [TIME_W-1:0]         time_ticks_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                phase_o;
  logic signed [STEER_W-1:0] steer_error_o;
  logic                      bypass_done_o;
  logic                      stop_car_o;

  bypass_scoreboard  sb;
  logic [DIST_W-1:0] dist_now;
  logic [TIME_W-1:0] clock_now;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int unsigned       cycle_cnt = 0;

  obstacle_bypass_sequencer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    steer_out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.phase = phase_o;
      got.steer = steer_error_o;
      got.done  = bypass_done_o;
      got.stop  = stop_car_o;
      sb.check_result(got);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [31:0] small_gains();
    return {16'($urandom_range(0, 16'h0A00)), 16'($urandom_range(0, 16'h0A00))};
  endfunction

  function automatic tick_t mk_tick(logic start, logic [DIST_W-1:0] odo, int heading,
                                    int coil, logic [TIME_W-1:0] ticks);
    tick_t t;
    t.start   = start;
    t.odo     = odo;
    t.heading = HEAD_W'(heading);
    t.coil    = COIL_W'(coil);
    t.ticks   = ticks;
    return t;
  endfunction

  // Odometer and clock advance coherently; the heading is pulled toward the
  // condition that moves the current phase on, the coil mostly kept low.
  function automatic tick_t make_tick(bit timeouts_on);
    tick_t t;
    int    sw_lim, rt_lim, roll, coil_roll;
    sw_lim = int'(sb.swerve_deg) * 256 - int'(ANGLE_MARGIN_Q8);
    rt_lim = int'(sb.return_deg) * 256 - int'(ANGLE_MARGIN_Q8);
    dist_now  = dist_now + DIST_W'($urandom_range(0, 9));
    clock_now = clock_now + TIME_W'($urandom_range(1, 30));
    if (timeouts_on && $urandom_range(0, 99) < 3)
      clock_now = clock_now + TIME_W'($urandom_range(20000, 60000));
    t.start = (sb.ph == PH_IDLE) ? ($urandom_range(0, 99) < 25) : ($urandom_range(0, 99) < 10);
    t.heading = HEAD_W'(rand_between(-HEAD_MAX, HEAD_MAX));
    t.coil    = COIL_W'($urandom);
    roll = int'($urandom_range(0, 99));
    if (roll < 6) begin
      // teleport the odometer; scramble the clock only once timeouts are wanted
      dist_now = DIST_W'($urandom);
      if (timeouts_on) clock_now = $urandom;
    end else begin
      if (sb.ph != PH_IDLE && roll < 80) begin
        coil_roll = int'($urandom_range(0, 99));
        if (coil_roll >= 35) t.coil = COIL_W'(rand_between(-100, 30));
        else if (coil_roll >= 15) t.coil = COIL_W'(rand_between(30, 260));
      end
      if (roll < 60) begin
        case (sb.ph)
          PH_SWERVE:
            t.heading = HEAD_W'(sb.left ? rand_between(sw_lim + 1, HEAD_MAX)
                                        : rand_between(-HEAD_MAX, -sw_lim - 1));
          PH_BYPASS:
            t.heading = HEAD_W'(sb.left ? rand_between(-HEAD_MAX, -rt_lim - 1)
                                        : rand_between(rt_lim + 1, HEAD_MAX));
          PH_RETURN:
            t.heading = HEAD_W'(rand_between(-7679, 7679));
          default: ;
        endcase
      end
    end
    t.odo   = dist_now;
    t.ticks = clock_now;
    return t;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic left, logic [ANGLE_W-1:0] sw_deg,
                            logic [ANGLE_W-1:0] rt_deg, logic [31:0] gs,
                            logic [31:0] gb, logic [31:0] gt);
    apb_write(REG_BYPASS_LEFT, {31'b0, left});
    apb_write(REG_SWERVE_ANGLE, {25'b0, sw_deg});
    apb_write(REG_RETURN_ANGLE, {25'b0, rt_deg});
    apb_write(REG_GAINS_SWERVE, gs);
    apb_write(REG_GAINS_BYPASS, gb);
    apb_write(REG_GAINS_STRGHT, gt);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_tick(tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    start_request_i   <= t.start;
    travel_distance_i <= t.odo;
    heading_angle_i   <= t.heading;
    center_coil_i     <= t.coil;
    time_ticks_i      <= t.ticks;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_tick(t);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_steer_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    sb                = new();
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid_i        = 1'b0;
    start_request_i   = 1'b0;
    travel_distance_i = '0;
    heading_angle_i   = '0;
    center_coil_i     = '0;
    time_ticks_i      = '0;
    dist_now          = DIST_W'($urandom_range(0, 1 << 20));
    clock_now         = 32'hFFFF_C000 + $urandom_range(0, 4095);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Left bypass walked edge by edge: thresholds hit exactly, then passed
    set_config(1'b1, 7'd30, 7'd30, 32'h0180_0100, 32'hFFFF_FFFF, 32'h0040_0200);
    send_tick(mk_tick(1'b0, 31'h7FFF_FFFF, HEAD_MAX, 32767, 32'hFFFF_FFFF));
    send_tick(mk_tick(1'b0, 31'd0, -HEAD_MAX, -32768, 32'd0));
    send_tick(mk_tick(1'b1, 31'd1000, 0, 0, 32'd100));
    send_tick(mk_tick(1'b1, 31'd1030, 3000, 0, 32'd150));     // start while busy
    send_tick(mk_tick(1'b0, 31'd1060, 9000, 0, 32'd200));
    send_tick(mk_tick(1'b0, 31'd1061, 6401, 0, 32'd250));
    send_tick(mk_tick(1'b0, 31'd1101, -6401, 0, 32'd300));
    send_tick(mk_tick(1'b0, 31'd1102, -6401, 0, 32'd350));
    send_tick(mk_tick(1'b0, 31'd1132, 0, 40, 32'd400));
    send_tick(mk_tick(1'b0, 31'd1133, 7680, 40, 32'd450));
    send_tick(mk_tick(1'b0, 31'd1134, -7679, 36, 32'd500));   // completion
    send_tick(mk_tick(1'b0, 31'd1200, 0, 0, 32'd550));
    wait_idle();

    // Right bypass with out-of-range angles; exits from return and from bypass
    set_config(1'b0, 7'd127, 7'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0000);
    send_tick(mk_tick(1'b1, 31'd5000, 0, 0, 32'd1000));
    send_tick(mk_tick(1'b0, 31'd5061, -31233, 0, 32'd1010));
    send_tick(mk_tick(1'b0, 31'd5070, 5000, 201, 32'd1020));
    send_tick(mk_tick(1'b0, 31'd5092, -1279, 0, 32'd1030));
    send_tick(mk_tick(1'b0, 31'd5123, 0, 181, 32'd1040));
    send_tick(mk_tick(1'b1, 31'd5124, 0, 0, 32'd1050));
    send_tick(mk_tick(1'b0, 31'd5100, -HEAD_MAX, 0, 32'd1060)); // odometer behind mark
    send_tick(mk_tick(1'b0, 31'd5186, -HEAD_MAX, 0, 32'd1070));
    send_tick(mk_tick(1'b0, 31'd5217, -2000, 51, 32'd1080));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(1'b1, 7'd30, 7'd30, small_gains(), small_gains(), small_gains());
        1: set_config(1'b0, 7'd0, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_config(1'b1, 7'd127, 7'd127, 32'h0, 32'h0, 32'h0);
        3: set_config(1'b0, 7'd90, 7'd90, $urandom, $urandom, $urandom);
        default: set_config(1'($urandom_range(0, 1)), 7'($urandom_range(0, 90)),
                            7'($urandom_range(0, 90)), small_gains(), $urandom,
                            small_gains());
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      // hold the clock coherent early so the sticky stop flag stays low a while
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_tick(make_tick(p >= TIMEOUT_PHASE));
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_steer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/obs_pkg.sv
rtl/obs_phase_ctrl.sv
rtl/obs_steer_scale.sv
rtl/obstacle_bypass_sequencer.sv
bench/tb_obstacle_bypass_sequencer.sv
